// ===== design/rwjc_pkg.sv =====
// ----------------------------------------------------------------------------
// rwjc_pkg
// Shared types, register indexes, reset values and the CORDIC angle table
// for the ramped waveform joint command generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rwjc_pkg;

	localparam int MAX_JOINTS_DEF = 8;

	// configuration register indexes
	localparam logic [2:0] REG_AMPLITUDE  = 3'd0;
	localparam logic [2:0] REG_PHASE_STEP = 3'd1;
	localparam logic [2:0] REG_RAMP_STEP  = 3'd2;
	localparam logic [2:0] REG_WAVEFORM   = 3'd3;
	localparam logic [2:0] REG_JOINT_CNT  = 3'd4;

	// input operation codes
	localparam logic OP_REPORT = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// waveform codes
	localparam logic WAVE_SINE     = 1'b0;
	localparam logic WAVE_TRIANGLE = 1'b1;

	// register reset values
	localparam logic signed [24:0] AMPLITUDE_RST  = 25'sd0;
	localparam logic [31:0]        PHASE_STEP_RST = 32'd26843546;
	localparam logic [16:0]        RAMP_STEP_RST  = 17'd819;
	localparam logic [3:0]         JOINT_CNT_RST  = 4'd1;

	// amplitude limit, +-0.5 rad in Q1.24
	localparam logic signed [24:0] AMP_CAP     = 25'sd8388608;
	localparam logic signed [24:0] AMP_CAP_NEG = -25'sd8388608;

	// 1.0 in Q1.16
	localparam logic [16:0] RAMP_ONE = 17'd65536;

	localparam int CORDIC_ITERS = 24;
	localparam int CORDIC_IW    = $clog2(CORDIC_ITERS);
	localparam int CORDIC_W     = 34;
	// 1/K in Q4.30
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [3:0] {
		S_IDLE,
		S_COPY_RD,
		S_COPY_WR,
		S_ADVANCE,
		S_CORDIC,
		S_SHAPE,
		S_MUL1,
		S_MUL2,
		S_OFFSET,
		S_OUT_RD,
		S_OUT_LD,
		S_OUT_WAIT
	} state_t;

	// atan(2^-i) as a fraction of a full cycle, scaled by 2^32
	function automatic logic [31:0] atan_lut(input logic [CORDIC_IW-1:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== design/ramped_waveform_joint_command.sv =====
// ----------------------------------------------------------------------------
// ramped_waveform_joint_command
// Position reports are stored per joint. The first tick after every joint in
// use is known latches the centres (one copy read and one copy write per
// joint) and from then on each tick advances a phase accumulator and a Q1.16
// ramp, forms a sine (24-step CORDIC on one shared shift-add unit, one step a
// cycle) or a triangle, scales it by amplitude*ramp in two registered
// multiplies, and sends centre+offset for each joint in use, the final one
// marked last. Input is stalled for the whole tick. There is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ramped_waveform_joint_command #(
	parameter int MAX_JOINTS = rwjc_pkg::MAX_JOINTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,

	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               op,
	input  wire logic [2:0]         joint_index,
	input  wire logic signed [31:0] position,

	output logic                    cmd_valid,
	input  wire logic               cmd_stall,
	output logic [2:0]              out_joint,
	output logic signed [31:0]      command_position,
	output logic                    last
);

	import rwjc_pkg::*;

	localparam int IDXW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int CW   = $clog2(MAX_JOINTS + 1);

	state_t state_q, state_d;

	// configuration
	logic signed [24:0] amplitude_q;
	logic [31:0]        phase_step_q;
	logic [16:0]        ramp_step_q;
	logic               wave_q;
	logic [3:0]         joint_count_q;

	// control state
	logic [MAX_JOINTS-1:0] known_q;
	logic                  centred_q;
	logic [31:0]           phase_acc_q;
	logic [16:0]           ramp_level_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         n_q;
	logic                  cmd_valid_q;

	// datapath
	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic                       neg_q;
	logic [CORDIC_IW-1:0]       it_q;
	logic signed [17:0]         shape_q;
	logic signed [33:0]         rs_q;
	logic signed [58:0]         prod_q;
	logic signed [26:0]         offset_q;
	logic [2:0]                 out_joint_q;
	logic signed [31:0]         cmd_pos_q;
	logic                       last_q;

	// memories
	logic signed [31:0] latest_mem [MAX_JOINTS];
	logic signed [31:0] centre_mem [MAX_JOINTS];
	logic signed [31:0] lat_rd_q;
	logic signed [31:0] ctr_rd_q;

	logic [CW-1:0]   n_d;
	logic [MAX_JOINTS-1:0] need_ok;
	logic            all_known;
	logic            req_xfer;
	logic            cnt_last;
	logic            rpt_in_range;
	logic [IDXW-1:0] wr_addr;
	logic [IDXW-1:0] rd_addr;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign cnt_last  = ((cnt_q + CW'(1)) == n_q);
	assign rpt_in_range = (int'(joint_index) < MAX_JOINTS);
	assign wr_addr   = IDXW'(joint_index);
	assign rd_addr   = cnt_q[IDXW-1:0];

	assign cmd_valid        = cmd_valid_q;
	assign out_joint        = out_joint_q;
	assign command_position = cmd_pos_q;
	assign last             = last_q;

	// joints in use, clamped to 1..MAX_JOINTS
	always_comb begin
		if (joint_count_q == 4'd0) begin
			n_d = CW'(1);
		end else if (int'(joint_count_q) > MAX_JOINTS) begin
			n_d = CW'(MAX_JOINTS);
		end else begin
			n_d = CW'(joint_count_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_JOINTS; i++) begin
			need_ok[i] = known_q[i] || (i >= int'(n_d));
		end
		all_known = &need_ok;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_xfer && op == OP_TICK) begin
					if (centred_q) begin
						state_d = S_ADVANCE;
					end else if (all_known) begin
						state_d = S_COPY_RD;
					end
				end
			end
			S_COPY_RD: state_d = S_COPY_WR;
			S_COPY_WR: state_d = cnt_last ? S_ADVANCE : S_COPY_RD;
			S_ADVANCE: state_d = (wave_q == WAVE_TRIANGLE) ? S_SHAPE : S_CORDIC;
			S_CORDIC: begin
				if (it_q == CORDIC_IW'(CORDIC_ITERS - 1)) begin
					state_d = S_SHAPE;
				end
			end
			S_SHAPE:  state_d = S_MUL1;
			S_MUL1:   state_d = S_MUL2;
			S_MUL2:   state_d = S_OFFSET;
			S_OFFSET: state_d = S_OUT_RD;
			S_OUT_RD: state_d = S_OUT_LD;
			S_OUT_LD: state_d = S_OUT_WAIT;
			S_OUT_WAIT: begin
				if (!cmd_stall) begin
					state_d = cnt_last ? S_IDLE : S_OUT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- configuration ----------------
	logic signed [24:0] amp_wr;

	always_comb begin
		amp_wr = $signed(cfg_data[24:0]);
		if (amp_wr > AMP_CAP) begin
			amp_wr = AMP_CAP;
		end else if (amp_wr < AMP_CAP_NEG) begin
			amp_wr = AMP_CAP_NEG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q   <= AMPLITUDE_RST;
			phase_step_q  <= PHASE_STEP_RST;
			ramp_step_q   <= RAMP_STEP_RST;
			wave_q        <= WAVE_SINE;
			joint_count_q <= JOINT_CNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AMPLITUDE:  amplitude_q   <= amp_wr;
				REG_PHASE_STEP: phase_step_q  <= cfg_data;
				REG_RAMP_STEP:  ramp_step_q   <= cfg_data[16:0];
				REG_WAVEFORM:   wave_q        <= cfg_data[0];
				REG_JOINT_CNT:  joint_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ---------------- phase and ramp ----------------
	logic [31:0] phase_next;
	logic [16:0] ramp_inc;
	logic [17:0] ramp_sum;

	assign phase_next = phase_acc_q + phase_step_q;
	assign ramp_inc   = (ramp_step_q == 17'd0) ? RAMP_ONE : ramp_step_q;
	assign ramp_sum   = {1'b0, ramp_level_q} + {1'b0, ramp_inc};

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q      <= '0;
			centred_q    <= 1'b0;
			phase_acc_q  <= '0;
			ramp_level_q <= '0;
			cnt_q        <= '0;
			n_q          <= CW'(1);
			cmd_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						if (op == OP_REPORT) begin
							if (rpt_in_range) begin
								known_q[wr_addr] <= 1'b1;
							end
						end else begin
							cnt_q <= '0;
							n_q   <= n_d;
						end
					end
				end
				S_COPY_WR: begin
					if (cnt_last) begin
						centred_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_ADVANCE: begin
					phase_acc_q <= phase_next;
					if (ramp_sum > {1'b0, RAMP_ONE}) begin
						ramp_level_q <= RAMP_ONE;
					end else begin
						ramp_level_q <= ramp_sum[16:0];
					end
				end
				S_OFFSET: cnt_q <= '0;
				S_OUT_LD: cmd_valid_q <= 1'b1;
				S_OUT_WAIT: begin
					if (!cmd_stall) begin
						cmd_valid_q <= 1'b0;
						if (!cnt_last) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (req_xfer && op == OP_REPORT && rpt_in_range) begin
			latest_mem[wr_addr] <= position;
		end
		lat_rd_q <= latest_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_COPY_WR) begin
			centre_mem[rd_addr] <= lat_rd_q;
		end
		ctr_rd_q <= centre_mem[rd_addr];
	end

	// ---------------- shared CORDIC shift-add unit ----------------
	logic [31:0]                fold_sum;
	logic [31:0]                fold_ph;
	logic signed [CORDIC_W-1:0] dx_w, dy_w, at_w;

	assign fold_sum = phase_next + 32'h4000_0000;
	assign fold_ph  = {phase_next[31] ^ fold_sum[31], phase_next[30:0]};
	assign dx_w     = y_q >>> it_q;
	assign dy_w     = x_q >>> it_q;
	assign at_w     = $signed({2'b00, atan_lut(it_q)});

	// ---------------- shape ----------------
	logic signed [CORDIC_W-1:0] sin_w;
	logic signed [17:0]         sin_sat;
	logic signed [18:0]         tri_ph;
	logic signed [18:0]         tri_w;

	assign sin_w  = (y_q + CORDIC_W'(8192)) >>> 14;
	assign tri_ph = $signed({1'b0, phase_acc_q[31:14]});

	always_comb begin
		if (sin_w > CORDIC_W'(65536)) begin
			sin_sat = 18'sd65536;
		end else if (sin_w < -CORDIC_W'(65536)) begin
			sin_sat = -18'sd65536;
		end else begin
			sin_sat = sin_w[17:0];
		end
		if (!phase_acc_q[31]) begin
			tri_w = tri_ph - 19'sd65536;
		end else begin
			tri_w = 19'sd196608 - tri_ph;
		end
	end

	// ---------------- scale and output ----------------
	logic signed [35:0] rs_w;
	logic signed [58:0] prod_w;
	logic signed [58:0] rnd_w;
	logic signed [32:0] sum_w;

	assign rs_w   = $signed({1'b0, ramp_level_q}) * shape_q;
	assign prod_w = amplitude_q * rs_q;
	assign rnd_w  = prod_q + 59'sd2147483648;
	assign sum_w  = 33'(ctr_rd_q) + 33'(offset_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_ADVANCE: begin
				x_q   <= CORDIC_GAIN;
				y_q   <= '0;
				z_q   <= CORDIC_W'($signed(fold_ph));
				neg_q <= fold_sum[31];
				it_q  <= '0;
			end
			S_CORDIC: begin
				if (!z_q[CORDIC_W-1]) begin
					x_q <= x_q - dx_w;
					y_q <= y_q + dy_w;
					z_q <= z_q - at_w;
				end else begin
					x_q <= x_q + dx_w;
					y_q <= y_q - dy_w;
					z_q <= z_q + at_w;
				end
				it_q <= it_q + CORDIC_IW'(1);
			end
			S_SHAPE: begin
				if (wave_q == WAVE_TRIANGLE) begin
					shape_q <= tri_w[17:0];
				end else begin
					shape_q <= neg_q ? -sin_sat : sin_sat;
				end
			end
			S_MUL1:   rs_q     <= rs_w[33:0];
			S_MUL2:   prod_q   <= prod_w;
			S_OFFSET: offset_q <= rnd_w[58:32];
			S_OUT_LD: begin
				out_joint_q <= 3'(cnt_q);
				last_q      <= cnt_last;
				// saturate to the int32 range
				if (sum_w[32] != sum_w[31]) begin
					cmd_pos_q <= sum_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				end else begin
					cmd_pos_q <= sum_w[31:0];
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== dv/ramped_waveform_joint_command_test.sv =====
// ----------------------------------------------------------------------------
// ramped_waveform_joint_command_test
// Self-checking bench for the ramped waveform joint command generator.
// Position reports and ticks are sent in random bursts while the command
// side stalls on its own pattern, including one long hold-off. An in-bench
// model of the centring, phase, ramp, sine/triangle shape and saturation
// predicts every joint command, and each command is checked in order.
// ----------------------------------------------------------------------------

module ramped_waveform_joint_command_test;

	import rwjc_pkg::*;

	localparam longint GAIN_Q30     = 652032874;
	localparam longint I32_MAX      = 64'sd2147483647;
	localparam longint I32_MIN      = -64'sd2147483648;
	localparam int     QUIET_LIMIT  = 2000;
	localparam int     HOLD_CYCLES  = 400;
	localparam logic [2:0] REG_UNMAPPED = 3'd5;

	typedef struct {
		logic              op;
		logic [2:0]        joint;
		logic signed [31:0] pos;
	} joint_req_t;

	typedef struct {
		logic [2:0]         joint;
		logic signed [31:0] pos;
		logic               last;
	} joint_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               op = OP_REPORT;
	logic [2:0]         joint_index = '0;
	logic signed [31:0] position = '0;

	logic               cmd_valid;
	logic               cmd_stall = 1'b0;
	logic [2:0]         out_joint;
	logic signed [31:0] command_position;
	logic               last;

	ramped_waveform_joint_command u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.op               (op),
		.joint_index      (joint_index),
		.position         (position),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.out_joint        (out_joint),
		.command_position (command_position),
		.last             (last)
	);

	always #2 clk = ~clk;

	// model state
	logic signed [31:0] stored_pos [MAX_JOINTS_DEF];
	logic               pos_known  [MAX_JOINTS_DEF];
	logic signed [31:0] centre     [MAX_JOINTS_DEF];
	logic               centred = 1'b0;
	logic [31:0]        phase_acc = '0;
	logic [16:0]        ramp_lvl = '0;

	// model copy of the registers
	longint             amp_q24 = 0;
	logic [31:0]        phase_inc = PHASE_STEP_RST;
	logic [16:0]        ramp_inc = RAMP_STEP_RST;
	logic               wave_sel = WAVE_SINE;
	logic [3:0]         joint_cfg = JOINT_CNT_RST;

	joint_req_t pending_reqs [$];
	joint_cmd_t expected_cmds [$];
	joint_req_t cur_req;
	joint_cmd_t got_exp;

	int mismatches = 0;
	int ticks_sent = 0;
	int cmds_checked = 0;
	int inputs_taken = 0;
	int settings_used = 0;
	int burst_left = 0;
	int gap_left = 0;
	int rx_cycle = 0;
	int rx_mode = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int quiet_cycles = 0;

	initial begin
		for (int i = 0; i < MAX_JOINTS_DEF; i++) begin
			pos_known[i] = 1'b0;
		end
	end

	task automatic flag_mismatch(string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		mismatches++;
	endtask

	function automatic longint atan_turns(int i);
		longint v;
		case (i)
			0:  v = 536870912;
			1:  v = 316933406;
			2:  v = 167458907;
			3:  v = 85004756;
			4:  v = 42667331;
			5:  v = 21354465;
			6:  v = 10679838;
			7:  v = 5340245;
			8:  v = 2670163;
			9:  v = 1335087;
			10: v = 667544;
			11: v = 333772;
			12: v = 166886;
			13: v = 83443;
			14: v = 41722;
			15: v = 20861;
			16: v = 10430;
			17: v = 5215;
			18: v = 2608;
			19: v = 1304;
			20: v = 652;
			21: v = 326;
			22: v = 163;
			default: v = 81;
		endcase
		return v;
	endfunction

	// Q1.16 sine of a 32-bit cycle fraction
	function automatic longint cordic_sine(logic [31:0] ph);
		logic [31:0] p;
		logic [31:0] t;
		logic        flip;
		int          zi;
		int          i;
		longint      x, y, z, dx, dy, s;
		p = ph;
		flip = 1'b0;
		t = p + 32'h4000_0000;
		// fold the left half plane back by half a cycle
		if (t[31]) begin
			p = p - 32'h8000_0000;
			flip = 1'b1;
		end
		zi = p;
		z = zi;
		x = GAIN_Q30;
		y = 0;
		for (i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_turns(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_turns(i);
			end
		end
		s = (y + 8192) >>> 14;
		if (s > 65536) s = 65536;
		if (s < -65536) s = -65536;
		return flip ? -s : s;
	endfunction

	function automatic longint triangle_wave(logic [31:0] ph);
		longint q;
		q = ph >> 14;
		if (!ph[31]) return q - 65536;
		return 196608 - q;
	endfunction

	task automatic load_register(logic [2:0] idx, logic [31:0] data);
		logic signed [24:0] a25;
		case (idx)
			REG_AMPLITUDE: begin
				a25 = data[24:0];
				amp_q24 = a25;
				if (amp_q24 > AMP_CAP) amp_q24 = AMP_CAP;
				if (amp_q24 < AMP_CAP_NEG) amp_q24 = AMP_CAP_NEG;
			end
			REG_PHASE_STEP: phase_inc = data;
			REG_RAMP_STEP:  ramp_inc = data[16:0];
			REG_WAVEFORM:   wave_sel = data[0];
			REG_JOINT_CNT:  joint_cfg = data[3:0];
			default: ;
		endcase
	endtask

	task automatic predict_commands(joint_req_t r);
		int          n;
		int          j;
		logic        all_known;
		logic [16:0] inc;
		logic [17:0] lvl;
		longint      rl, shape, offs, c, cj;
		joint_cmd_t  e;
		if (r.op == OP_REPORT) begin
			stored_pos[r.joint] = r.pos;
			pos_known[r.joint] = 1'b1;
			return;
		end
		n = (joint_cfg == 0) ? 1 : ((joint_cfg > MAX_JOINTS_DEF) ? MAX_JOINTS_DEF : joint_cfg);
		if (!centred) begin
			all_known = 1'b1;
			for (j = 0; j < n; j++) begin
				if (!pos_known[j]) all_known = 1'b0;
			end
			// no centre yet: the tick is dropped
			if (!all_known) return;
			for (j = 0; j < n; j++) begin
				centre[j] = stored_pos[j];
			end
			centred = 1'b1;
		end
		phase_acc = phase_acc + phase_inc;
		inc = (ramp_inc == 0) ? RAMP_ONE : ramp_inc;
		lvl = ramp_lvl + inc;
		ramp_lvl = (lvl > RAMP_ONE) ? RAMP_ONE : lvl[16:0];
		shape = (wave_sel == WAVE_TRIANGLE) ? triangle_wave(phase_acc) : cordic_sine(phase_acc);
		rl = ramp_lvl;
		offs = (amp_q24 * rl * shape + (64'sd1 <<< 31)) >>> 32;
		for (j = 0; j < n; j++) begin
			cj = centre[j];
			c = cj + offs;
			if (c > I32_MAX) c = I32_MAX;
			if (c < I32_MIN) c = I32_MIN;
			e.joint = j[2:0];
			e.pos = c[31:0];
			e.last = (j == n - 1);
			expected_cmds.insert(expected_cmds.size(), e);
		end
	endtask

	// request driver: bursts of random length, random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_commands(cur_req);
				if (cur_req.op == OP_TICK) ticks_sent++;
				inputs_taken <= inputs_taken + 1;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					req_valid <= 1'b1;
					op <= cur_req.op;
					joint_index <= cur_req.joint;
					position <= cur_req.pos;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// command side stall pattern, with one long hold-off once traffic is flowing
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_stall <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
			if (!hold_done && inputs_taken >= 40) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				cmd_stall <= 1'b1;
			end else begin
				case (rx_mode)
					0: cmd_stall <= 1'b0;
					1: cmd_stall <= 1'($urandom_range(0, 1));
					2: cmd_stall <= (rx_cycle % 4 != 0);
					default: cmd_stall <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) begin
			cmds_checked++;
			if (expected_cmds.size() == 0) begin
				flag_mismatch($sformatf("unexpected command joint %0d position %0d",
					out_joint, command_position));
			end else begin
				got_exp = expected_cmds.pop_front();
				if (out_joint !== got_exp.joint)
					flag_mismatch($sformatf("out_joint %0d, want %0d", out_joint, got_exp.joint));
				if (command_position !== got_exp.pos)
					flag_mismatch($sformatf("joint %0d command_position %0d, want %0d",
						got_exp.joint, command_position, got_exp.pos));
				if (last !== got_exp.last)
					flag_mismatch($sformatf("joint %0d last %0b, want %0b",
						got_exp.joint, last, got_exp.last));
			end
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (cmd_valid && !cmd_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] watchdog: no transfer for %0d cycles, %0d commands outstanding",
					$time, QUIET_LIMIT, expected_cmds.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		load_register(idx, data);
	endtask

	task automatic push_req(logic o, logic [2:0] j, logic [31:0] p);
		joint_req_t r;
		r.op = o;
		r.joint = j;
		r.pos = p;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic wait_idle(int settle);
		do @(posedge clk);
		while (pending_reqs.size() != 0 || req_valid || expected_cmds.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic random_phase(int k);
		logic [31:0] amp_w;
		logic [31:0] step_w;
		logic [31:0] ramp_w;
		logic [31:0] cnt_w;
		int          i;
		case ($urandom_range(0, 3))
			0: amp_w = $urandom;
			1: amp_w = $urandom_range(0, 8388608);
			2: amp_w = -int'($urandom_range(0, 8388608));
			default: amp_w = {7'd0, AMP_CAP_NEG};
		endcase
		case ($urandom_range(0, 3))
			0: step_w = $urandom;
			1: step_w = $urandom_range(1, 32'h0400_0000);
			2: step_w = 32'hFFFF_FFFF;
			default: step_w = 32'h8000_0000;
		endcase
		// keep the ramp climbing early; zero and oversized steps come later
		if (k < 3) ramp_w = $urandom_range(100, 3000);
		else if (k == 3) ramp_w = 32'd0;
		else if (k == 4) ramp_w = 32'h0001_FFFF;
		else ramp_w = $urandom;
		if (k == 1) cnt_w = 32'd0;
		else if (k == 2) cnt_w = 32'd8;
		else cnt_w = $urandom_range(0, 15);
		write_reg(REG_AMPLITUDE, amp_w);
		write_reg(REG_PHASE_STEP, step_w);
		write_reg(REG_RAMP_STEP, ramp_w);
		write_reg(REG_WAVEFORM, $urandom);
		write_reg(REG_JOINT_CNT, cnt_w);
		if (k == 2) write_reg(REG_UNMAPPED, $urandom);
		settings_used++;
		@(negedge clk);
		for (i = 0; i < 45; i++) begin
			push_req(($urandom_range(0, 19) < 13) ? OP_TICK : OP_REPORT,
				3'($urandom_range(0, 7)), $urandom);
		end
	endtask

	initial begin
		int k;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// centring: ticks are dropped until all eight joints have reported
		write_reg(REG_JOINT_CNT, 32'd15);
		write_reg(REG_AMPLITUDE, 32'h00FF_FFFF);
		settings_used++;
		@(negedge clk);
		push_req(OP_TICK, 3'd0, 32'd0);
		push_req(OP_REPORT, 3'd0, 32'h7FFF_FFFF);
		push_req(OP_REPORT, 3'd1, 32'h8000_0000);
		push_req(OP_REPORT, 3'd2, 32'h0000_0000);
		push_req(OP_REPORT, 3'd3, 32'hFFFF_FFFF);
		push_req(OP_REPORT, 3'd4, 32'h0000_0001);
		push_req(OP_REPORT, 3'd5, 32'h5555_5555);
		push_req(OP_REPORT, 3'd6, 32'hAAAA_AAAA);
		push_req(OP_TICK, 3'd7, 32'hFFFF_FFFF);
		push_req(OP_REPORT, 3'd7, 32'h1234_5678);
		push_req(OP_REPORT, 3'd4, 32'hFFFF_0000);
		push_req(OP_TICK, 3'd0, 32'd0);
		push_req(OP_TICK, 3'd0, 32'd0);
		push_req(OP_TICK, 3'd0, 32'd0);
		wait_idle(16);

		// triangle at quarter-cycle steps, negative saturated amplitude, minimum ramp
		write_reg(REG_AMPLITUDE, 32'hFF00_0000);
		write_reg(REG_WAVEFORM, 32'(WAVE_TRIANGLE));
		write_reg(REG_PHASE_STEP, 32'h4000_0000);
		write_reg(REG_RAMP_STEP, 32'd1);
		write_reg(REG_JOINT_CNT, 32'd3);
		write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
		settings_used++;
		@(negedge clk);
		push_req(OP_TICK, 3'd0, 32'd0);
		push_req(OP_TICK, 3'd0, 32'd0);
		push_req(OP_REPORT, 3'd2, 32'h7FFF_FFFF);
		push_req(OP_TICK, 3'd0, 32'd0);
		push_req(OP_TICK, 3'd0, 32'd0);
		push_req(OP_TICK, 3'd0, 32'd0);
		wait_idle(16);

		for (k = 0; k < 6; k++) begin
			random_phase(k);
			wait_idle(16);
		end
		repeat (48) @(posedge clk);

		if (expected_cmds.size() != 0)
			flag_mismatch($sformatf("%0d commands never arrived", expected_cmds.size()));
		$display("Summary: %0d requests (%0d ticks), %0d joint commands checked, %0d settings",
			inputs_taken, ticks_sent, cmds_checked, settings_used);
		$display("Covered sine and triangle, saturated amplitude and position, ramp steps 0..max");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
